FILE: design/text_console_cell_writer_assert.svh
// Assertion macros shared by the text console cell writer modules.
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define TCW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("text console cell writer: assertion failed");
// Checked at every clock edge, also while reset is applied.
`define TCW_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("text console cell writer: assertion failed");
`else
`define TCW_ASSERT(label, clk, rst_n, prop)
`define TCW_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: design/tcw_pkg.sv
// Types, constants and codes shared by the text console cell writer modules.
package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int ACTION_W  = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int CELL_W    = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] NEWLINE_BYTE    = 8'd10;
    localparam logic [CELL_W-1:0] ATTRIBUTE_RESET = 16'h0700;
    localparam logic [CELL_W-1:0] BLANK_RESET     = 16'h0720;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [0:0] {
        REG_ATTRIBUTE = 1'b0,
        REG_BLANK     = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ_WAIT,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   character;
        logic [IDX_W-1:0]    cell_index;
    } item_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_column;
        logic [CELL_W-1:0]    cell_value;
        logic                 scrolled;
    } result_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] character;
        logic [IDX_W-1:0]  cell_index;
        logic              in_range;
    } cmd_t;

endpackage

FILE: design/text_console_cell_writer.sv
// Top level of the text console cell writer: register port and the three stages.
//
// A text screen of ROWS x COLUMNS 16-bit cells with a cursor, driven through
// queue-style ports: push an item while full is low, pop a result while empty
// is low; every item returns exactly one result in order. After reset the
// block sweeps the whole cell store to the reset blank value, one cell per
// cycle, and holds full high until that pass is done.
// Commands are decoded into a two-entry queue, so the producer can keep going
// while the engine works, and results wait in a two-entry queue on the way out.
// In the engine, a read goes through a registered memory read. A scroll copies
// the store up a row, each cell by a read state and then a write state, and
// then fills the bottom row with the blank value; a clear fills the whole store.
// Register writes are always ready and should be made while idle.
module text_console_cell_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  tcw_pkg::item_t             item,
    output logic                       empty,
    input  logic                       pop,
    output tcw_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [0:0]                 cfg_index,
    input  logic [tcw_pkg::CELL_W-1:0] cfg_data
);

    logic [tcw_pkg::CELL_W-1:0] attribute_reg;
    logic [tcw_pkg::CELL_W-1:0] attribute_next;
    logic [tcw_pkg::CELL_W-1:0] blank_reg;
    logic [tcw_pkg::CELL_W-1:0] blank_next;

    tcw_pkg::cmd_t    cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    logic             init_busy;
    logic             res_full;
    logic             res_push;
    tcw_pkg::result_t res_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        attribute_next = attribute_reg;
        blank_next     = blank_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                tcw_pkg::REG_ATTRIBUTE: attribute_next = cfg_data;
                tcw_pkg::REG_BLANK:     blank_next     = cfg_data;
                default:
                begin
                    attribute_next = attribute_reg;
                    blank_next     = blank_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attribute_reg <= tcw_pkg::ATTRIBUTE_RESET;
            blank_reg     <= tcw_pkg::BLANK_RESET;
        end
        else
        begin
            attribute_reg <= attribute_next;
            blank_reg     <= blank_next;
        end
    end

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .init_busy (init_busy),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .attribute_word (attribute_reg),
        .blank_cell     (blank_reg),
        .cmd            (cmd),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .init_busy      (init_busy),
        .res_full       (res_full),
        .res_push       (res_push),
        .res_data       (res_data)
    );

    tcw_result_queue u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

FILE: design/tcw_front.sv
// Front end: decodes incoming items into commands and queues them for the engine.
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  tcw_pkg::item_t  item,
    input  logic            init_busy,
    output tcw_pkg::cmd_t   cmd,
    output logic            cmd_valid,
    input  logic            cmd_pop
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int IDX_W      = tcw_pkg::IDX_W;
    localparam int CMP_W      = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;
    localparam int DEPTH      = tcw_pkg::QUEUE_DEPTH;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    tcw_pkg::cmd_t    q_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] tail;
    logic             accept;
    tcw_pkg::cmd_t    decoded;

    always_comb
    begin
        decoded.character  = item.character;
        decoded.cell_index = item.cell_index;
        decoded.in_range   = CMP_W'(item.cell_index) < CMP_W'(CELL_COUNT);
        case (item.action)
            tcw_pkg::ACT_PUT:
            begin
                if (item.character == tcw_pkg::NEWLINE_BYTE)
                    decoded.op = tcw_pkg::OP_NEWLINE;
                else
                    decoded.op = tcw_pkg::OP_PUT;
            end
            tcw_pkg::ACT_CLEAR: decoded.op = tcw_pkg::OP_CLEAR;
            tcw_pkg::ACT_READ:  decoded.op = tcw_pkg::OP_READ;
            default:            decoded.op = tcw_pkg::OP_NONE;
        endcase
    end

    // No item is taken while the engine is still sweeping the store after reset.
    assign full      = (count_reg == CNT_W'(DEPTH)) || init_busy;
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[head_reg];
    assign tail      = PTR_W'(head_reg + PTR_W'(count_reg));

    always_comb
    begin
        count_next = count_reg + CNT_W'(accept) - CNT_W'(cmd_pop);
        head_next  = cmd_pop ? PTR_W'(head_reg + 1'b1) : head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg[tail] <= decoded;
    end

endmodule

FILE: design/tcw_back.sv
// Back end: the cell store, the cursor and the sequencer that runs each command.
`include "text_console_cell_writer_assert.svh"
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tcw_pkg::CELL_W-1:0] attribute_word,
    input  logic [tcw_pkg::CELL_W-1:0] blank_cell,
    input  tcw_pkg::cmd_t              cmd,
    input  logic                       cmd_valid,
    output logic                       cmd_pop,
    output logic                       init_busy,
    input  logic                       res_full,
    output logic                       res_push,
    output tcw_pkg::result_t           res_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int CELL_W     = tcw_pkg::CELL_W;
    localparam int ROW_OUT_W  = tcw_pkg::ROW_OUT_W;
    localparam int COL_OUT_W  = tcw_pkg::COL_OUT_W;

    localparam logic [ADDR_W-1:0] CELL_LAST   = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST   = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);

    logic [CELL_W-1:0] mem [CELL_COUNT];

    tcw_pkg::state_t   state_reg;
    tcw_pkg::state_t   state_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] base_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic              clear_reg;
    logic              clear_next;
    logic [CELL_W-1:0] rdata_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic              row_step;
    logic [CELL_W-1:0] res_cell;
    logic              res_scrolled;

    assign init_busy = (state_reg == tcw_pkg::ST_INIT);

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        base_next    = base_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        clear_next   = clear_reg;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = blank_cell;
        mem_re       = 1'b0;
        mem_raddr    = addr_reg + ROW_STRIDE;
        cmd_pop      = 1'b0;
        row_step     = 1'b0;
        res_push     = 1'b0;
        res_cell     = '0;
        res_scrolled = 1'b0;

        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = tcw_pkg::BLANK_RESET;
                if (addr_reg == CELL_LAST)
                begin
                    addr_next  = '0;
                    state_next = tcw_pkg::ST_IDLE;
                end
                else
                    addr_next = addr_reg + 1'b1;
            end
            tcw_pkg::ST_IDLE:
            begin
                // A command starts only when its result has a slot waiting for it.
                if (cmd_valid && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        tcw_pkg::OP_PUT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = base_reg + ADDR_W'(col_reg);
                            mem_wdata = attribute_word | CELL_W'(cmd.character);
                            if (col_reg == COL_LAST)
                                row_step = 1'b1;
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                res_push = 1'b1;
                            end
                        end
                        tcw_pkg::OP_NEWLINE:
                            row_step = 1'b1;
                        tcw_pkg::OP_CLEAR:
                        begin
                            addr_next  = '0;
                            clear_next = 1'b1;
                            state_next = tcw_pkg::ST_FILL;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            if (cmd.in_range)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = ADDR_W'(cmd.cell_index);
                                state_next = tcw_pkg::ST_READ_WAIT;
                            end
                            else
                                res_push = 1'b1;
                        end
                        default:
                            res_push = 1'b1;
                    endcase

                    if (row_step)
                    begin
                        col_next = '0;
                        if (row_reg == ROW_LAST)
                        begin
                            addr_next  = '0;
                            state_next = tcw_pkg::ST_SCROLL_RD;
                        end
                        else
                        begin
                            row_next  = row_reg + 1'b1;
                            base_next = base_reg + ROW_STRIDE;
                            res_push  = 1'b1;
                        end
                    end
                end
            end
            tcw_pkg::ST_READ_WAIT:
            begin
                res_push   = 1'b1;
                res_cell   = rdata_reg;
                state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_SCROLL_RD:
            begin
                mem_re     = 1'b1;
                state_next = tcw_pkg::ST_SCROLL_WR;
            end
            tcw_pkg::ST_SCROLL_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                if (addr_reg == COPY_LAST)
                begin
                    addr_next  = BOTTOM_BASE;
                    clear_next = 1'b0;
                    state_next = tcw_pkg::ST_FILL;
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    state_next = tcw_pkg::ST_SCROLL_RD;
                end
            end
            tcw_pkg::ST_FILL:
            begin
                mem_we = 1'b1;
                if (addr_reg == CELL_LAST)
                begin
                    addr_next  = '0;
                    res_push   = 1'b1;
                    state_next = tcw_pkg::ST_IDLE;
                    if (clear_reg)
                    begin
                        row_next  = '0;
                        col_next  = '0;
                        base_next = '0;
                    end
                    else
                        res_scrolled = 1'b1;
                end
                else
                    addr_next = addr_reg + 1'b1;
            end
            default:
                state_next = tcw_pkg::ST_IDLE;
        endcase

        res_data.cursor_row    = ROW_OUT_W'(row_next);
        res_data.cursor_column = COL_OUT_W'(col_next);
        res_data.cell_value    = res_cell;
        res_data.scrolled      = res_scrolled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_INIT;
            addr_reg  <= '0;
            base_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            clear_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            base_reg  <= base_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            clear_reg <= clear_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    `TCW_ASSERT(a_result_has_room, clk, rst_n, res_push |-> !res_full)
    `TCW_ASSERT(a_pop_only_idle, clk, rst_n, cmd_pop |-> cmd_valid && state_reg == tcw_pkg::ST_IDLE)
    `TCW_ASSERT(a_cursor_in_screen, clk, rst_n, row_reg <= ROW_LAST && col_reg <= COL_LAST)
    `TCW_ASSERT(a_read_answers_next, clk, rst_n, state_reg == tcw_pkg::ST_READ_WAIT |-> res_push)
    `TCW_ASSERT_ALWAYS(a_reset_starts_sweep, clk, !rst_n |=> state_reg == tcw_pkg::ST_INIT)

endmodule

FILE: design/tcw_result_queue.sv
// Result queue: holds finished results until the consumer pops them.
module tcw_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  tcw_pkg::result_t res_data,
    output logic             res_full,
    input  logic             pop,
    output logic             empty,
    output tcw_pkg::result_t result
);

    localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcw_pkg::result_t q_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] tail;
    logic             take;

    assign empty    = (count_reg == '0);
    assign res_full = (count_reg == CNT_W'(DEPTH));
    assign result   = q_reg[head_reg];
    assign take     = pop && !empty;
    assign tail     = PTR_W'(head_reg + PTR_W'(count_reg));

    always_comb
    begin
        count_next = count_reg + CNT_W'(res_push) - CNT_W'(take);
        head_next  = take ? PTR_W'(head_reg + 1'b1) : head_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            q_reg[tail] <= res_data;
    end

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the text console cell writer with directed and random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS       = tcw_pkg::COLUMNS_DEFAULT;
    localparam int ROWS       = tcw_pkg::ROWS_DEFAULT;
    localparam int CELL_COUNT = COLS * ROWS;
    localparam int IDLE_PCT   = 21;
    localparam logic [tcw_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       push      = 1'b0;
    logic                       full;
    tcw_pkg::item_t             push_item = '0;
    logic                       empty;
    logic                       pop       = 1'b0;
    tcw_pkg::result_t           pop_result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    tcw_pkg::cfg_reg_t          cfg_index = tcw_pkg::REG_ATTRIBUTE;
    logic [tcw_pkg::CELL_W-1:0] cfg_data  = '0;

    // Predicted screen, cursor and register state.
    logic [tcw_pkg::CELL_W-1:0] screen_mem [0:CELL_COUNT-1];
    logic [tcw_pkg::CELL_W-1:0] attr_reg;
    logic [tcw_pkg::CELL_W-1:0] blank_reg;
    int                         cursor_row;
    int                         cursor_col;

    tcw_pkg::result_t           expected_q[$];
    int                         error_count = 0;
    int                         pop_hold    = 0;
    bit                         idling_on   = 1'b1;

    text_console_cell_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (push_item),
        .empty     (empty),
        .pop       (pop),
        .result    (pop_result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic void fill_screen(input logic [tcw_pkg::CELL_W-1:0] value);
        for (int k = 0; k < CELL_COUNT; k++)
            screen_mem[k] = value;
    endfunction

    // Moves the cursor to the start of the next row, scrolling at the bottom.
    function automatic logic advance_row();
        cursor_col = 0;
        cursor_row++;
        if (cursor_row < ROWS)
            return 1'b0;
        for (int k = 0; k < (ROWS - 1) * COLS; k++)
            screen_mem[k] = screen_mem[k + COLS];
        for (int k = (ROWS - 1) * COLS; k < CELL_COUNT; k++)
            screen_mem[k] = blank_reg;
        cursor_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic tcw_pkg::result_t console_step(input tcw_pkg::item_t it);
        tcw_pkg::result_t r;
        r = '0;
        case (it.action)
            tcw_pkg::ACT_PUT:
            begin
                if (it.character == tcw_pkg::NEWLINE_BYTE)
                    r.scrolled = advance_row();
                else
                begin
                    screen_mem[cursor_row * COLS + cursor_col] =
                        attr_reg | {8'h00, it.character};
                    cursor_col++;
                    if (cursor_col >= COLS)
                        r.scrolled = advance_row();
                end
            end
            tcw_pkg::ACT_CLEAR:
            begin
                fill_screen(blank_reg);
                cursor_row = 0;
                cursor_col = 0;
            end
            tcw_pkg::ACT_READ:
            begin
                if (it.cell_index < CELL_COUNT)
                    r.cell_value = screen_mem[it.cell_index];
            end
            default: ;
        endcase
        r.cursor_row    = tcw_pkg::ROW_OUT_W'(cursor_row);
        r.cursor_column = tcw_pkg::COL_OUT_W'(cursor_col);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Result consumer: holds off on request, otherwise pops with random gaps, or without gaps when idling is off.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold > 0)
        begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else if (idling_on)
            pop <= ($urandom_range(0, 99) >= IDLE_PCT);
        else
            pop <= 1'b1;
    end

    // Tracks register writes and accepted items, and checks every popped result.
    always @(posedge clk)
    begin : result_check
        tcw_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tcw_pkg::REG_ATTRIBUTE)
                    attr_reg = cfg_data;
                else
                    blank_reg = cfg_data;
            end
            if (push && !full)
                expected_q.push_back(console_step(push_item));
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("transaction with nothing pending", 32'(pop_result), '0);
                else
                begin
                    want = expected_q.pop_front();
                    if (pop_result.cursor_row !== want.cursor_row)
                        report_mismatch("cursor_row", 32'(pop_result.cursor_row),
                                        32'(want.cursor_row));
                    if (pop_result.cursor_column !== want.cursor_column)
                        report_mismatch("cursor_column", 32'(pop_result.cursor_column),
                                        32'(want.cursor_column));
                    if (pop_result.cell_value !== want.cell_value)
                        report_mismatch("cell_value", 32'(pop_result.cell_value),
                                        32'(want.cell_value));
                    if (pop_result.scrolled !== want.scrolled)
                        report_mismatch("scrolled", 32'(pop_result.scrolled),
                                        32'(want.scrolled));
                end
            end
        end
    end

    function automatic tcw_pkg::item_t make_item(input logic [tcw_pkg::ACTION_W-1:0] action,
                                                 input logic [tcw_pkg::CHAR_W-1:0] character,
                                                 input int index);
        tcw_pkg::item_t it;
        it.action     = action;
        it.character  = character;
        it.cell_index = tcw_pkg::IDX_W'(index);
        return it;
    endfunction

    function automatic logic [tcw_pkg::CHAR_W-1:0] text_byte();
        logic [tcw_pkg::CHAR_W-1:0] c;
        do
            c = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        while (c == tcw_pkg::NEWLINE_BYTE);
        return c;
    endfunction

    function automatic tcw_pkg::item_t random_item();
        tcw_pkg::item_t it;
        int             pick;
        int             where;
        pick  = $urandom_range(0, 199);
        where = $urandom_range(0, 9);
        it.character  = tcw_pkg::CHAR_W'($urandom_range(0, 255));
        it.cell_index = tcw_pkg::IDX_W'($urandom_range(0, CELL_COUNT - 1));
        if (pick == 0)
            it.action = tcw_pkg::ACT_CLEAR;
        else if (pick < 5)
            it.action = ACT_UNUSED;
        else if (pick < 55)
        begin
            it.action = tcw_pkg::ACT_READ;
            // Favor the cursor row, where fresh text and scrolled rows show up.
            if (where < 5)
                it.cell_index = tcw_pkg::IDX_W'(cursor_row * COLS
                                                + $urandom_range(0, COLS - 1));
            else if (where == 9)
                it.cell_index = tcw_pkg::IDX_W'($urandom_range(CELL_COUNT,
                                                               (1 << tcw_pkg::IDX_W) - 1));
        end
        else
        begin
            it.action = tcw_pkg::ACT_PUT;
            if ($urandom_range(0, 4) == 0)
                it.character = tcw_pkg::NEWLINE_BYTE;
        end
        return it;
    endfunction

    task automatic send_item(input tcw_pkg::item_t next_item);
        if (idling_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT);
        end
        push      <= 1'b1;
        push_item <= next_item;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic wait_idle(input int settle);
        push <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_registers(input logic [tcw_pkg::CELL_W-1:0] attr,
                                 input logic [tcw_pkg::CELL_W-1:0] blank);
        cfg_valid <= 1'b1;
        cfg_index <= tcw_pkg::REG_ATTRIBUTE;
        cfg_data  <= attr;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= tcw_pkg::REG_BLANK;
        cfg_data  <= blank;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Reads with the register values from reset, including out-of-range indexes.
    task automatic test_reset_state();
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 0));
        send_item(make_item(tcw_pkg::ACT_READ, 8'hFF, CELL_COUNT - 1));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, CELL_COUNT));
        send_item(make_item(tcw_pkg::ACT_READ, 8'hFF, (1 << tcw_pkg::IDX_W) - 1));
        wait_idle(8);
    endtask

    task automatic test_basic_ops();
        set_registers(16'hA500, 16'h0000);
        send_item(make_item(tcw_pkg::ACT_PUT, 8'h00, 0));
        send_item(make_item(tcw_pkg::ACT_PUT, 8'hFF, (1 << tcw_pkg::IDX_W) - 1));
        send_item(make_item(tcw_pkg::ACT_PUT, 8'h41, 0));
        send_item(make_item(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_BYTE, 0));
        send_item(make_item(ACT_UNUSED, 8'hFF, (1 << tcw_pkg::IDX_W) - 1));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 0));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 1));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 2));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, COLS));
        send_item(make_item(tcw_pkg::ACT_CLEAR, 8'hFF, (1 << tcw_pkg::IDX_W) - 1));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 0));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, CELL_COUNT - 1));
        send_item(make_item(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_BYTE, 0));
        wait_idle(8);
    endtask

    // Fills a full line to force a wrap, walks to the bottom row, then scrolls
    // once by newline and once by wrapping off the last column.
    task automatic test_wrap_and_scroll();
        set_registers(16'h0000, 16'hFFFF);
        send_item(make_item(tcw_pkg::ACT_CLEAR, 8'h00, 0));
        repeat (COLS) send_item(make_item(tcw_pkg::ACT_PUT, text_byte(), 0));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 0));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, COLS - 1));
        repeat (ROWS - 2) send_item(make_item(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_BYTE, 0));
        repeat (3) send_item(make_item(tcw_pkg::ACT_PUT, text_byte(), 0));
        send_item(make_item(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_BYTE, 0));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, (ROWS - 2) * COLS));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, (ROWS - 1) * COLS));
        repeat (COLS) send_item(make_item(tcw_pkg::ACT_PUT, text_byte(), 0));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, (ROWS - 2) * COLS + COLS - 1));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, CELL_COUNT - 1));
        send_item(make_item(tcw_pkg::ACT_READ, 8'h00, 0));
        wait_idle(8);
    endtask

    task automatic test_backpressure();
        pop_hold = 400;
        repeat (14) send_item(random_item());
        wait_idle(8);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    idling_on = 1'b0;
                    set_registers(tcw_pkg::ATTRIBUTE_RESET, tcw_pkg::BLANK_RESET);
                end
                1:
                begin
                    idling_on = 1'b1;
                    set_registers(16'hFFFF, 16'h0000);
                end
                default:
                    set_registers(tcw_pkg::CELL_W'($urandom_range(0, 16'hFFFF)),
                                  tcw_pkg::CELL_W'($urandom_range(0, 16'hFFFF)));
            endcase
            repeat (150) send_item(random_item());
            wait_idle(20);
        end
    endtask

    initial
    begin
        attr_reg   = tcw_pkg::ATTRIBUTE_RESET;
        blank_reg  = tcw_pkg::BLANK_RESET;
        cursor_row = 0;
        cursor_col = 0;
        fill_screen(tcw_pkg::BLANK_RESET);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_basic_ops();
        test_wrap_and_scroll();
        test_backpressure();
        test_random_traffic();

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/tcw_pkg.sv
design/tcw_front.sv
design/tcw_back.sv
design/tcw_result_queue.sv
design/text_console_cell_writer.sv
sim/tb.sv
